// ===== sv/sfd_pkg.sv =====
// shared constants and types for the slip frame decoder
`timescale 1ns / 1ps
package sfd_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int LEN_W         = 7;
    localparam int Q_DEPTH       = 2;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic REQ_BYTE       = 1'b0;
    localparam logic REQ_SOFT_RESET = 1'b1;

    localparam logic STATUS_DATA     = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // drain command from front to back
    typedef struct packed {
        logic             ovf;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

// ===== sv/sfd_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface sfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       status;

    modport source (output valid, output out_byte, output last, output status, input ready);
    modport sink (input valid, input out_byte, input last, input status, output ready);
endinterface

// ===== sv/sfd_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sfd_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
module sfd_queue
    import sfd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_cmd                         i_data,
    input  logic                         i_pop,
    output t_cmd                         o_data,
    output logic                         o_empty,
    output logic [$clog2(Q_DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign w_push = i_push && (r_count != CW'(Q_DEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ===== sv/sfd_front.sv =====
// front end: takes requests, undoes escaping, fills the frame store
`timescale 1ns / 1ps
module sfd_front
    import sfd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sfd_in_if.sink                       i_in,
    input  logic                         i_q_empty,
    input  logic                         i_back_idle,
    output logic                         o_wr_en,
    output logic [$clog2(MAX_FRAME)-1:0] o_wr_addr,
    output logic [7:0]                   o_wr_data,
    output logic                         o_cmd_valid,
    output t_cmd                         o_cmd
);

    localparam int AW = $clog2(MAX_FRAME);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_esc;
    logic             n_esc;
    logic             r_ovf;
    logic             n_ovf;
    logic             w_accept;
    logic             w_store;
    logic [7:0]       w_store_data;

    // intake waits while a frame drains out of the store
    assign i_in.ready = i_q_empty && i_back_idle;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_len        = r_len;
        n_esc        = r_esc;
        n_ovf        = r_ovf;
        w_store      = 1'b0;
        w_store_data = i_in.in_byte;
        o_cmd_valid  = 1'b0;
        o_cmd.ovf    = r_ovf;
        o_cmd.len    = r_len;
        o_wr_en      = 1'b0;
        if (w_accept) begin
            if (i_in.req_type == REQ_SOFT_RESET) begin
                n_len = '0;
                n_esc = 1'b0;
                n_ovf = 1'b0;
            end else if (i_in.in_byte == SLIP_END) begin
                if ((r_len != '0) || r_ovf) begin
                    if (!r_esc) begin
                        o_cmd_valid = 1'b1;
                    end
                    n_esc = 1'b0;
                    n_len = '0;
                    n_ovf = 1'b0;
                end
            end else if (i_in.in_byte == SLIP_ESC) begin
                n_esc = 1'b1;
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_in.in_byte == SLIP_ESC_END) begin
                    w_store      = 1'b1;
                    w_store_data = SLIP_END;
                end else if (i_in.in_byte == SLIP_ESC_ESC) begin
                    w_store      = 1'b1;
                    w_store_data = SLIP_ESC;
                end else begin
                    n_len = '0;
                    n_ovf = 1'b0;
                end
            end else begin
                w_store = 1'b1;
            end
            if (w_store) begin
                if (r_len == LEN_W'(MAX_FRAME)) begin
                    n_ovf = 1'b1;
                end else begin
                    o_wr_en = 1'b1;
                    n_len   = r_len + 1'b1;
                end
            end
        end
    end

    assign o_wr_addr = r_len[AW-1:0];
    assign o_wr_data = w_store_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_esc <= 1'b0;
            r_ovf <= 1'b0;
        end else begin
            r_len <= n_len;
            r_esc <= n_esc;
            r_ovf <= n_ovf;
        end
    end

endmodule

// ===== sv/sfd_back.sv =====
// back end: drains a finished frame or reports an overflow
`timescale 1ns / 1ps
module sfd_back
    import sfd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  t_cmd                         i_cmd,
    output logic                         o_pop,
    output logic                         o_idle,
    output logic                         o_rd_en,
    output logic [$clog2(MAX_FRAME)-1:0] o_rd_addr,
    input  logic [7:0]                   i_rd_data,
    sfd_out_if.source                    o_out
);

    localparam int AW = $clog2(MAX_FRAME);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] n_idx;
    logic             r_ovf;
    logic             r_rd_pend;
    logic             n_rd_pend;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_status;
    logic             w_slot_free;
    logic             w_load;
    logic [7:0]       w_load_byte;
    logic             w_load_last;
    logic             w_load_status;

    assign w_slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_rd_pend     = r_rd_pend;
        o_pop         = 1'b0;
        o_rd_en       = 1'b0;
        w_load        = 1'b0;
        w_load_byte   = i_rd_data;
        w_load_last   = 1'b0;
        w_load_status = STATUS_DATA;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_idx   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_ovf) begin
                    if (w_slot_free) begin
                        w_load        = 1'b1;
                        w_load_byte   = '0;
                        w_load_last   = 1'b1;
                        w_load_status = STATUS_OVERFLOW;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    // one read in flight, landing straight in the output register
                    if (r_rd_pend) begin
                        w_load      = 1'b1;
                        w_load_last = (r_idx == r_len);
                        n_rd_pend   = 1'b0;
                        if (r_idx == r_len) begin
                            n_state = ST_IDLE;
                        end
                    end else if (w_slot_free) begin
                        o_rd_en   = 1'b1;
                        n_idx     = r_idx + 1'b1;
                        n_rd_pend = 1'b1;
                    end
                end
            end
            default: begin
                n_state   = ST_IDLE;
                n_rd_pend = 1'b0;
            end
        endcase
    end

    assign o_rd_addr = r_idx[AW-1:0];

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop) begin
            r_len <= i_cmd.len;
            r_ovf <= i_cmd.ovf;
        end
        if (w_load) begin
            r_out_byte   <= w_load_byte;
            r_out_last   <= w_load_last;
            r_out_status <= w_load_status;
        end
    end

    assign o_idle         = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;
    assign o_out.status   = r_out_status;

endmodule

// ===== sv/slip_frame_decoder.sv =====
// top level of the slip frame decoder
`timescale 1ns / 1ps
// SLIP receive decoder. Raw link bytes (or soft-reset requests) enter on i_in and are
// un-escaped into a frame store of MAX_FRAME bytes; an END closing a non-empty frame
// releases it on o_out as a run of bytes with last on the final one, or as a single
// overflow result (out_byte 0, last 1, status 1) if the frame grew past MAX_FRAME.
// A request is taken when no frame is draining. While a frame drains, intake is held;
// the store has one registered read port and each byte takes a read plus a load into
// the output register. An overflow result holds intake as well, and a stall on o_out
// of a waiting result lengthens the hold. An END straight after an ESC drops the
// frame. The last result of a run may still wait on o_out while new requests are
// taken.
module slip_frame_decoder
    import sfd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfd_in_if.sink     i_in,
    sfd_out_if.source  o_out
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;
    logic          w_cmd_valid;
    t_cmd          w_cmd_in;
    t_cmd          w_cmd_out;
    logic          w_pop;
    logic          w_q_empty;
    logic [CW-1:0] w_q_count;
    logic          w_back_idle;

    sfd_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_empty   (w_q_empty),
        .i_back_idle (w_back_idle),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd_in)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sfd_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_cmd_out),
        .o_pop     (w_pop),
        .o_idle    (w_back_idle),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_out     (o_out)
    );

    // the store is never written while a frame is being read out
    a_no_write_during_drain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (w_back_idle && w_q_empty)
    ) else $error("frame store written during drain");

    // at most one drain command outstanding
    a_queue_depth: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= CW'(1)
    ) else $error("more than one drain command queued");

    // an overflow result is a lone, zero, final result
    a_overflow_form: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == STATUS_OVERFLOW))
            |-> (o_out.last && (o_out.out_byte == 8'h00))
    ) else $error("malformed overflow result");

    // a closing command only comes from an accepted request
    a_cmd_from_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_valid |-> (i_in.valid && i_in.ready)
    ) else $error("drain command without request");

endmodule

// ===== sim/testbench.sv =====
// testbench for the slip frame decoder: directed and random link traffic against a predictor
`timescale 1ns / 1ps
module testbench;
    import sfd_pkg::*;

    localparam int FRAME_CAP      = MAX_FRAME_DEF;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_WAIT     = 200;
    localparam int TOTAL_REQUESTS = 185;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       status;
    } t_decoded;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfd_in_if  req_if ();
    sfd_out_if res_if ();

    slip_frame_decoder #(
        .MAX_FRAME(FRAME_CAP)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // predictor state
    logic [7:0] rx_frame [FRAME_CAP];
    int         rx_len;
    logic       rx_esc;
    logic       rx_ovf;
    t_decoded   decoded_q [$];

    int          mismatch_count = 0;
    int          requests_sent  = 0;
    int          quiet_cycles   = 0;
    int unsigned gap_max        = 14;
    int unsigned stall_max      = 14;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void store_decoded(input logic [7:0] b);
        if (rx_len >= FRAME_CAP) begin
            rx_ovf = 1'b1;
        end else begin
            rx_frame[rx_len] = b;
            rx_len++;
        end
    endfunction

    function automatic void decode_slip_request(input logic rtype, input logic [7:0] b);
        t_decoded d;
        if (rtype == REQ_SOFT_RESET) begin
            rx_len = 0;
            rx_ovf = 1'b0;
            rx_esc = 1'b0;
        end else if (b == SLIP_END) begin
            if (rx_len == 0 && !rx_ovf) begin
                // empty frame, escape mark kept
            end else if (rx_esc) begin
                rx_esc = 1'b0;
                rx_len = 0;
                rx_ovf = 1'b0;
            end else if (rx_ovf) begin
                d.data   = 8'h00;
                d.last   = 1'b1;
                d.status = STATUS_OVERFLOW;
                decoded_q.insert(decoded_q.size(), d);
                rx_len = 0;
                rx_ovf = 1'b0;
            end else begin
                for (int i = 0; i < rx_len; i++) begin
                    d.data   = rx_frame[i];
                    d.last   = (i == rx_len - 1);
                    d.status = STATUS_DATA;
                    decoded_q.insert(decoded_q.size(), d);
                end
                rx_len = 0;
            end
        end else if (b == SLIP_ESC) begin
            rx_esc = 1'b1;
        end else if (rx_esc) begin
            if (b == SLIP_ESC_END) begin
                store_decoded(SLIP_END);
            end else if (b == SLIP_ESC_ESC) begin
                store_decoded(SLIP_ESC);
            end else begin
                rx_len = 0;
                rx_ovf = 1'b0;
            end
            rx_esc = 1'b0;
        end else begin
            store_decoded(b);
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic rtype, input logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= rtype;
        req_if.in_byte  <= b;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        decode_slip_request(rtype, b);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_escaped(input logic [7:0] b);
        if (b == SLIP_END) begin
            send_request(REQ_BYTE, SLIP_ESC);
            send_request(REQ_BYTE, SLIP_ESC_END);
        end else if (b == SLIP_ESC) begin
            send_request(REQ_BYTE, SLIP_ESC);
            send_request(REQ_BYTE, SLIP_ESC_ESC);
        end else begin
            send_request(REQ_BYTE, b);
        end
    endtask

    task automatic send_soft_reset();
        send_request(REQ_SOFT_RESET, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: return SLIP_END;
                1: return SLIP_ESC;
                2: return SLIP_ESC_END;
                default: return SLIP_ESC_ESC;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // result sink with random stalls
    initial begin
        int unsigned stall;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && res_if.valid === 1'b1));
        end
    end

    always @(posedge i_clk) begin
        t_decoded want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (decoded_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: byte %02h last %0b status %0b",
                             res_if.out_byte, res_if.last, res_if.status);
                mismatch_count++;
            end else begin
                want = decoded_q.pop_front();
                if (res_if.out_byte !== want.data || res_if.last !== want.last ||
                        res_if.status !== want.status) begin
                    if (mismatch_count < 10)
                        $display({"mismatch: expected byte %02h last %0b status %0b, ",
                                  "got byte %02h last %0b status %0b"},
                                 want.data, want.last, want.status,
                                 res_if.out_byte, res_if.last, res_if.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1) || i_rst_n !== 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_plain_frames();
        send_request(REQ_BYTE, 8'h00);
        send_request(REQ_BYTE, SLIP_END);
        send_request(REQ_BYTE, 8'hFF);
        send_request(REQ_BYTE, SLIP_END);
        send_request(REQ_BYTE, SLIP_END);
        send_request(REQ_BYTE, 8'h01);
        send_request(REQ_BYTE, 8'h80);
        send_request(REQ_BYTE, 8'h7F);
        send_request(REQ_BYTE, SLIP_END);
        // empty end keeps the escape mark
        send_request(REQ_BYTE, SLIP_ESC);
        send_request(REQ_BYTE, SLIP_END);
        send_request(REQ_BYTE, SLIP_ESC_END);
        send_request(REQ_BYTE, SLIP_END);
    endtask

    task automatic test_escapes();
        send_request(REQ_BYTE, 8'h10);
        send_escaped(SLIP_END);
        send_escaped(SLIP_ESC);
        send_request(REQ_BYTE, SLIP_END);
        // repeated escape stays pending
        send_request(REQ_BYTE, SLIP_ESC);
        send_request(REQ_BYTE, SLIP_ESC);
        send_request(REQ_BYTE, SLIP_ESC_ESC);
        send_request(REQ_BYTE, SLIP_END);
        // bad escape code clears the frame
        send_request(REQ_BYTE, 8'h20);
        send_request(REQ_BYTE, SLIP_ESC);
        send_request(REQ_BYTE, 8'h41);
        send_request(REQ_BYTE, 8'h30);
        send_request(REQ_BYTE, SLIP_END);
        // end straight after escape drops the frame
        send_request(REQ_BYTE, 8'h40);
        send_request(REQ_BYTE, SLIP_ESC);
        send_request(REQ_BYTE, SLIP_END);
        send_request(REQ_BYTE, 8'h50);
        send_request(REQ_BYTE, SLIP_END);
    endtask

    task automatic test_soft_reset();
        send_request(REQ_BYTE, 8'h60);
        send_request(REQ_BYTE, 8'h61);
        send_soft_reset();
        send_request(REQ_BYTE, SLIP_END);
        send_request(REQ_BYTE, SLIP_ESC);
        send_soft_reset();
        send_request(REQ_BYTE, SLIP_ESC_END);
        send_request(REQ_BYTE, SLIP_END);
        send_request(REQ_BYTE, 8'h70);
        send_request(REQ_SOFT_RESET, 8'hFF);
        send_request(REQ_BYTE, 8'h71);
        send_request(REQ_BYTE, SLIP_END);
    endtask

    task automatic test_long_frames();
        gap_max   = 2;
        stall_max = 3;
        // a frame that fills the store exactly
        repeat (FRAME_CAP) send_request(REQ_BYTE, 8'($urandom_range(0, 191)));
        send_request(REQ_BYTE, SLIP_END);
        // one byte too many gives a single overflow result
        repeat (FRAME_CAP + 1) send_request(REQ_BYTE, 8'($urandom_range(0, 191)));
        send_request(REQ_BYTE, SLIP_END);
        gap_max   = 14;
        stall_max = 14;
    endtask

    task automatic test_random_traffic();
        int unsigned kind;
        int unsigned len;
        while (requests_sent < TOTAL_REQUESTS) begin
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 14;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            kind      = $urandom_range(0, 99);
            if (kind < 70) begin
                len = $urandom_range(1, 8);
                repeat (len) send_escaped(pick_byte());
                send_request(REQ_BYTE, SLIP_END);
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 10)) send_request(REQ_BYTE, pick_byte());
                send_request(REQ_BYTE, SLIP_END);
            end else if (kind < 93) begin
                repeat ($urandom_range(0, 5)) send_escaped(pick_byte());
                if ($urandom_range(0, 1) == 1)
                    send_request(REQ_BYTE, SLIP_ESC);
                send_soft_reset();
            end else begin
                repeat ($urandom_range(1, 8))
                    send_request(1'($urandom_range(0, 1)), pick_byte());
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_BYTE;
        req_if.in_byte  = 8'h00;
        rx_len          = 0;
        rx_esc          = 1'b0;
        rx_ovf          = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_plain_frames();
        test_escapes();
        test_soft_reset();
        test_long_frames();
        test_random_traffic();

        req_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== slip_frame_decoder.f =====
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_ram.sv
sv/sfd_queue.sv
sv/sfd_front.sv
sv/sfd_back.sv
sv/slip_frame_decoder.sv
sim/testbench.sv
